@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ hdl/i2cmbe_pkg.sv @@
// Package with the types and codes of the I2C master bit engine.
package i2cmbe_pkg;

   // Command codes as they arrive on the request channel.
   localparam logic [2:0] CMD_TICK  = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_STOP  = 3'd2;
   localparam logic [2:0] CMD_WRITE = 3'd3;
   localparam logic [2:0] CMD_READ  = 3'd4;

   localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;
   localparam logic [3:0] BITS_PER_BYTE     = 4'd8;
   localparam int         QUEUE_DEPTH       = 2;

   // Command class after decoding; unknown codes become plain ticks.
   typedef enum logic [2:0] {
      KIND_TICK,
      KIND_START,
      KIND_STOP,
      KIND_WRITE,
      KIND_READ
   } cmd_kind_type;

   // One decoded tick waiting for the bus sequencer.
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   tx_byte;
      logic         send_ack;
      logic         sda_in;
   } tick_entry_type;

   // Bus sequencer phases.
   typedef enum logic [3:0] {
      PH_IDLE,
      PH_SA, PH_SB, PH_SC,
      PH_PA, PH_PB, PH_PC,
      PH_WA, PH_WB, PH_WC,
      PH_AR, PH_AP,
      PH_RA, PH_RB, PH_RC
   } phase_type;

endpackage

@@ hdl/i2cmbe_front.sv @@
// Front end: accepts request ticks and classifies their commands.
module i2cmbe_front import i2cmbe_pkg::*; (
   input  logic           req_valid,
   output logic           req_stall,
   input  logic [2:0]     req_cmd,
   input  logic [7:0]     req_tx_byte,
   input  logic           req_send_ack,
   input  logic           req_sda_in,
   input  logic           queue_full,
   output logic           push,
   output tick_entry_type push_entry
);

   // A transfer is taken whenever the queue has room.
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // Decode the command code into its class.
   always_comb begin
      case (req_cmd)
         CMD_START: push_entry.kind = KIND_START;
         CMD_STOP:  push_entry.kind = KIND_STOP;
         CMD_WRITE: push_entry.kind = KIND_WRITE;
         CMD_READ:  push_entry.kind = KIND_READ;
         default:   push_entry.kind = KIND_TICK;
      endcase
      push_entry.tx_byte  = req_tx_byte;
      push_entry.send_ack = req_send_ack;
      push_entry.sda_in   = req_sda_in;
   end

endmodule

@@ hdl/i2cmbe_queue.sv @@
// Two-entry queue between the front end and the bus sequencer.
module i2cmbe_queue import i2cmbe_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  tick_entry_type push_entry,
   input  logic           pop,
   output logic           not_empty,
   output logic           full,
   output tick_entry_type head_entry
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   tick_entry_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]         count_ff, count_in;

   assign not_empty  = count_ff != '0;
   assign full       = count_ff == CNT_W'(QUEUE_DEPTH);
   assign head_entry = slot_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

@@ hdl/i2cmbe_back.sv @@
// Bus sequencer: one tick per cycle unless stalled; registers the response.
module i2cmbe_back import i2cmbe_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_wr_en,
   input  logic [7:0]     csr_wr_data,
   input  logic           q_not_empty,
   input  tick_entry_type q_entry,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output logic           rsp_scl,
   output logic           rsp_sda_level,
   output logic           rsp_sda_drive,
   output logic           rsp_busy_res,
   output logic           rsp_done_res,
   output logic [7:0]     rsp_rx_byte,
   output logic           rsp_nack
);

   phase_type  phase_ff, phase_in, eff_phase;
   logic [3:0] bit_count_ff, bit_count_in, bc_eff, bc_inc;
   logic [7:0] shift_ff, shift_in, sh_eff;
   logic [7:0] wait_ff, wait_in;
   logic       ack_choice_ff, ack_choice_in, ackc_eff;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in_nx;
   logic       drive_ff, drive_in;
   logic       nack_ff, nack_in;
   logic [7:0] rx_hold_ff, rx_hold_in;
   logic       done;
   logic [7:0] ack_timeout_ff;
   logic       rsp_valid_ff, rsp_valid_in;

   // Work on the head tick when the output register is free or being drained.
   assign pop       = q_not_empty && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign bc_inc    = bc_eff + 1'b1;

   // An idle sequencer starts the sequence the tick's command asks for.
   always_comb begin
      eff_phase = phase_ff;
      sh_eff    = shift_ff;
      bc_eff    = bit_count_ff;
      ackc_eff  = ack_choice_ff;
      if (phase_ff == PH_IDLE) begin
         case (q_entry.kind)
            KIND_START: eff_phase = PH_SA;
            KIND_STOP:  eff_phase = PH_PA;
            KIND_WRITE: begin
               eff_phase = PH_WA;
               sh_eff    = q_entry.tx_byte;
               bc_eff    = '0;
            end
            KIND_READ: begin
               eff_phase = PH_RA;
               sh_eff    = '0;
               bc_eff    = '0;
               ackc_eff  = q_entry.send_ack;
            end
            default: ;
         endcase
      end
   end

   // Next phase.
   always_comb begin
      case (eff_phase)
         PH_SA: phase_in = PH_SB;
         PH_SB: phase_in = PH_SC;
         PH_SC: phase_in = PH_IDLE;
         PH_PA: phase_in = PH_PB;
         PH_PB: phase_in = PH_PC;
         PH_PC: phase_in = PH_IDLE;
         PH_WA: phase_in = PH_WB;
         PH_WB: phase_in = PH_WC;
         PH_WC: phase_in = (bc_inc >= BITS_PER_BYTE) ? PH_AR : PH_WA;
         PH_AR: phase_in = PH_AP;
         PH_AP: begin
            if (!q_entry.sda_in) begin
               phase_in = PH_IDLE;
            end else if (wait_ff >= ack_timeout_ff) begin
               phase_in = PH_PB;
            end else begin
               phase_in = PH_AP;
            end
         end
         PH_RA: phase_in = PH_RB;
         PH_RB: phase_in = PH_RC;
         PH_RC: phase_in = (bc_eff >= BITS_PER_BYTE) ? PH_IDLE : PH_RA;
         default: phase_in = PH_IDLE;
      endcase
   end

   // Pin levels, counters and status for the current phase.
   always_comb begin
      shift_in      = sh_eff;
      bit_count_in  = bc_eff;
      ack_choice_in = ackc_eff;
      wait_in       = wait_ff;
      scl_in        = scl_ff;
      sda_in_nx     = sda_ff;
      drive_in      = drive_ff;
      nack_in       = nack_ff;
      rx_hold_in    = rx_hold_ff;
      done          = 1'b0;
      case (eff_phase)
         PH_SA: begin
            drive_in  = 1'b1;
            sda_in_nx = 1'b1;
            scl_in    = 1'b1;
         end
         PH_SB: sda_in_nx = 1'b0;
         PH_SC: begin
            scl_in = 1'b0;
            done   = 1'b1;
         end
         PH_PA: begin
            drive_in  = 1'b1;
            scl_in    = 1'b0;
            sda_in_nx = 1'b0;
         end
         PH_PB: scl_in = 1'b1;
         PH_PC: begin
            sda_in_nx = 1'b1;
            done      = 1'b1;
         end
         PH_WA: begin
            drive_in  = 1'b1;
            scl_in    = 1'b0;
            sda_in_nx = sh_eff[7];
            shift_in  = {sh_eff[6:0], 1'b0};
         end
         PH_WB: scl_in = 1'b1;
         PH_WC: begin
            scl_in       = 1'b0;
            bit_count_in = bc_inc;
         end
         PH_AR: begin
            drive_in  = 1'b0;
            sda_in_nx = 1'b1;
            scl_in    = 1'b1;
            wait_in   = '0;
         end
         PH_AP: begin
            if (!q_entry.sda_in) begin
               scl_in  = 1'b0;
               nack_in = 1'b0;
               done    = 1'b1;
            end else if (wait_ff >= ack_timeout_ff) begin
               // Timeout: flag it and begin the stop.
               nack_in   = 1'b1;
               drive_in  = 1'b1;
               scl_in    = 1'b0;
               sda_in_nx = 1'b0;
            end else begin
               wait_in = wait_ff + 1'b1;
            end
         end
         PH_RA: begin
            scl_in = 1'b0;
            if (bc_eff >= BITS_PER_BYTE) begin
               drive_in  = 1'b1;
               sda_in_nx = !ackc_eff;
            end else begin
               drive_in  = 1'b0;
               sda_in_nx = 1'b1;
            end
         end
         PH_RB: scl_in = 1'b1;
         PH_RC: begin
            if (bc_eff >= BITS_PER_BYTE) begin
               scl_in     = 1'b0;
               rx_hold_in = sh_eff;
               done       = 1'b1;
            end else begin
               shift_in     = {sh_eff[6:0], q_entry.sda_in};
               bit_count_in = bc_inc;
            end
         end
         default: ;
      endcase
   end

   // Response register holds until its transfer completes.
   always_comb begin
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   // Sequencer state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         bit_count_ff   <= '0;
         shift_ff       <= '0;
         wait_ff        <= '0;
         ack_choice_ff  <= 1'b0;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         drive_ff       <= 1'b1;
         nack_ff        <= 1'b0;
         rx_hold_ff     <= '0;
         ack_timeout_ff <= ACK_TIMEOUT_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            ack_timeout_ff <= csr_wr_data;
         end
         if (pop) begin
            phase_ff      <= phase_in;
            bit_count_ff  <= bit_count_in;
            shift_ff      <= shift_in;
            wait_ff       <= wait_in;
            ack_choice_ff <= ack_choice_in;
            scl_ff        <= scl_in;
            sda_ff        <= sda_in_nx;
            drive_ff      <= drive_in;
            nack_ff       <= nack_in;
            rx_hold_ff    <= rx_hold_in;
         end
      end
   end

   // Response payload, loaded with each processed tick.
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_scl       <= scl_in;
         rsp_sda_level <= sda_in_nx;
         rsp_sda_drive <= drive_in;
         rsp_busy_res  <= phase_in != PH_IDLE;
         rsp_done_res  <= done;
         rsp_rx_byte   <= rx_hold_in;
         rsp_nack      <= nack_in;
      end
   end

endmodule

@@ hdl/i2c_master_bit_engine.sv @@
// Top level of the I2C master bit engine: front end, tick queue, bus sequencer.
//
//   Channel   Direction  Handshake              Carries
//   req_      in         req_valid / req_stall  cmd, tx_byte, send_ack, sda_in
//   rsp_      out        rsp_valid / rsp_stall  scl, sda_level, sda_drive, busy_res,
//                                               done_res, rx_byte, nack
//   csr_      in         csr_wr_en              ack_timeout
//
// One tick is taken per cycle while the queue has room; its response is registered
// first in the queue and then in the sequencer's output register.
// Sustained rate is one tick per cycle while the response side does not stall.
// Synchronous reset idles the bus with SCL, SDA and drive high and ack_timeout at 250.
// A stall on the response side fills the two-entry queue, after which req_stall rises.
module i2c_master_bit_engine import i2cmbe_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_cmd,
   input  logic [7:0] req_tx_byte,
   input  logic       req_send_ack,
   input  logic       req_sda_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_scl,
   output logic       rsp_sda_level,
   output logic       rsp_sda_drive,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic [7:0] rsp_rx_byte,
   output logic       rsp_nack,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   logic           queue_full;
   logic           queue_not_empty;
   logic           push;
   logic           pop;
   tick_entry_type push_entry;
   tick_entry_type head_entry;

   // Decode incoming ticks.
   i2cmbe_front u_front (
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_cmd      (req_cmd),
      .req_tx_byte  (req_tx_byte),
      .req_send_ack (req_send_ack),
      .req_sda_in   (req_sda_in),
      .queue_full   (queue_full),
      .push         (push),
      .push_entry   (push_entry)
   );

   // Buffer between the two sides.
   i2cmbe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .not_empty  (queue_not_empty),
      .full       (queue_full),
      .head_entry (head_entry)
   );

   // Drive the bus waveform.
   i2cmbe_back u_back (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .q_not_empty   (queue_not_empty),
      .q_entry       (head_entry),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_scl       (rsp_scl),
      .rsp_sda_level (rsp_sda_level),
      .rsp_sda_drive (rsp_sda_drive),
      .rsp_busy_res  (rsp_busy_res),
      .rsp_done_res  (rsp_done_res),
      .rsp_rx_byte   (rsp_rx_byte),
      .rsp_nack      (rsp_nack)
   );

endmodule

@@ hdl/i2cmbe_checker.sv @@
// Port-level checks for the I2C master bit engine, bound to the top level.
`include "assert_macros.svh"

module i2cmbe_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_scl,
   input logic       rsp_sda_level,
   input logic       rsp_sda_drive,
   input logic       rsp_busy_res,
   input logic       rsp_done_res,
   input logic [7:0] rsp_rx_byte,
   input logic       rsp_nack
);

   logic [13:0] rsp_payload;

   // All response fields side by side, for the hold check.
   assign rsp_payload = {rsp_scl, rsp_sda_level, rsp_sda_drive, rsp_busy_res,
                         rsp_done_res, rsp_rx_byte, rsp_nack};

   // A finishing tick never reports the sequence as still running.
   `ASSERT_SAME(done_not_busy, clock, reset, rsp_valid && rsp_done_res, !rsp_busy_res)

   // A released data line always reads back as high.
   `ASSERT_SAME(released_reads_high, clock, reset, rsp_valid && !rsp_sda_drive, rsp_sda_level)

   // A stalled response stays offered.
   `ASSERT_NEXT(rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // A stalled response keeps its pin and status values.
   `ASSERT_NEXT(rsp_payload_held, clock, reset, rsp_valid && rsp_stall, $stable(rsp_payload))

endmodule

bind i2c_master_bit_engine i2cmbe_checker u_checker (.*);
